[hdl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SHAMH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shamh assertion failed");

// condition must never be seen outside reset
`define SHAMH_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("shamh forbidden condition seen");

`endif

[hdl/shamh_pkg.sv]
package shamh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_t;

    // top level sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_START,
        ST_WAIT,
        ST_OUT
    } top_state_t;

    // compression engine sequencer
    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_FINAL
    } comp_state_t;

    // commands from the top level to the compression engine
    typedef struct packed {
        logic       start;
        logic       restart;
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
    } ctl_t;

    // status back to the top level
    typedef struct packed {
        logic idle;
        logic done;
    } stat_t;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [6:0] LEN_START   = 7'd56;
    localparam logic [7:0] PAD_MARK    = 8'h80;

    localparam hash_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // one compression round, wk already holds w + k
    function automatic hash_t sha_round(input hash_t v, input word_t wk);
        word_t t1;
        word_t t2;
        word_t ch;
        word_t mj;
        hash_t r;
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + big_sigma1(v[4]) + ch + wk;
        t2 = big_sigma0(v[0]) + mj;
        r[7] = v[6];
        r[6] = v[5];
        r[5] = v[4];
        r[4] = v[3] + t1;
        r[3] = v[2];
        r[2] = v[1];
        r[1] = v[0];
        r[0] = t1 + t2;
        return r;
    endfunction

endpackage

[hdl/shamh_compress.sv]
module shamh_compress
    import shamh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctl_t  ctl,
    output stat_t stat,
    output hash_t chain
);

    comp_state_t cst_reg;
    comp_state_t cst_next;
    logic [6:0]  rnd_reg;
    logic [6:0]  rnd_next;
    hash_t       var_reg;
    hash_t       var_next;
    hash_t       chain_reg;
    hash_t       chain_next;
    word_t       win_reg [16];
    word_t       wk_reg;

    logic [5:0]  sidx;
    logic        sched_en;
    word_t       w_new;

    // schedule step runs one word ahead of the rounds
    always_comb
    begin
        sidx = (cst_reg == C_IDLE) ? 6'd0 : rnd_reg[5:0] + 6'd1;
        sched_en = (cst_reg == C_IDLE && ctl.start) ||
                   (cst_reg == C_ROUND && rnd_reg[5:0] != 6'd63);
        if (sidx[5:4] == 2'b00)
        begin
            w_new = win_reg[0];
        end
        else
        begin
            w_new = win_reg[0] + small_sigma0(win_reg[1]) + win_reg[9] +
                    small_sigma1(win_reg[14]);
        end
    end

    // block buffer doubles as the rolling schedule window
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            win_reg[ctl.wr_addr[5:2]][{~ctl.wr_addr[1:0], 3'b000} +: 8] <= ctl.wr_data;
        end
        else if (sched_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
        if (sched_en)
        begin
            wk_reg <= w_new + ROUND_K[sidx];
        end
    end

    // next state
    always_comb
    begin
        cst_next = cst_reg;
        unique case (cst_reg)
            C_IDLE:
            begin
                if (ctl.start)
                begin
                    cst_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                if (rnd_reg[5:0] == 6'd63)
                begin
                    cst_next = C_FINAL;
                end
            end
            C_FINAL:
            begin
                cst_next = C_IDLE;
            end
            default:
            begin
                cst_next = C_IDLE;
            end
        endcase
    end

    // round datapath and status
    always_comb
    begin
        rnd_next   = rnd_reg;
        var_next   = var_reg;
        chain_next = chain_reg;
        stat.idle  = 1'b0;
        stat.done  = 1'b0;
        unique case (cst_reg)
            C_IDLE:
            begin
                stat.idle = 1'b1;
                if (ctl.start)
                begin
                    var_next = chain_reg;
                    rnd_next = 7'd0;
                end
                if (ctl.restart)
                begin
                    chain_next = HASH_IV;
                end
            end
            C_ROUND:
            begin
                var_next = sha_round(var_reg, wk_reg);
                rnd_next = rnd_reg + 7'd1;
            end
            C_FINAL:
            begin
                stat.done = 1'b1;
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + var_reg[i];
                end
            end
            default:
            begin
                stat.idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cst_reg   <= C_IDLE;
            rnd_reg   <= 7'd0;
            var_reg   <= '0;
            chain_reg <= HASH_IV;
        end
        else
        begin
            cst_reg   <= cst_next;
            rnd_reg   <= rnd_next;
            var_reg   <= var_next;
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

[hdl/sha256_message_hasher_core.sv]
// SHA-256 hasher fed one message byte per beat.
// Input channel msg_valid/msg_ready carries has_byte, message_byte and
// end_of_message; a beat with end_of_message closes the message (its byte,
// if any, is hashed first). A beat with neither byte nor end mark is dropped.
// Output channel dig_valid/dig_ready carries the digest as four 64-bit beats,
// word_index 0 (most significant) first, last_word set on the fourth.
// A plain byte is written straight into the block buffer. Each filled
// 64-byte block then runs the shared round unit: one round per cycle,
// 64 rounds plus a start step and a final add. On the end mark, padding
// is written one byte per cycle, with a step that writes nothing closing
// each fill phase, followed by one compression, or two when more than 55
// bytes are pending; the first digest beat then shows in the next cycle.
// msg_ready is low whenever a block, padding or digest is in progress.
// A stalled digest beat holds until taken; the next message is accepted
// after the fourth beat leaves. Reset loads the initial hash values and
// clears the byte count and length, with no clearing pass.
module sha256_message_hasher_core
    import shamh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  logic        has_byte,
    input  logic [7:0]  message_byte,
    input  logic        end_of_message,
    output logic        dig_valid,
    input  logic        dig_ready,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    top_state_t  state_reg;
    top_state_t  state_next;
    top_state_t  ret_reg;
    top_state_t  ret_next;
    logic [6:0]  fill_reg;
    logic [6:0]  fill_next;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic        wrap_reg;
    logic        wrap_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;

    ctl_t        ctl;
    stat_t       stat;
    hash_t       chain;

    logic        msg_beat;
    logic        dig_beat;
    logic [6:0]  fill_after;
    logic        zero_done;

    assign msg_beat   = msg_valid && msg_ready;
    assign dig_beat   = dig_valid && dig_ready;
    assign fill_after = fill_reg + {6'd0, has_byte};
    assign zero_done  = wrap_reg ? (fill_reg == BLOCK_BYTES) : (fill_reg == LEN_START);

    shamh_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat),
        .chain (chain)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_beat)
                begin
                    priority if (fill_after == BLOCK_BYTES)
                    begin
                        state_next = ST_START;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (zero_done)
                begin
                    state_next = wrap_reg ? ST_START : ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (fill_reg == BLOCK_BYTES)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.idle)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (stat.done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_OUT:
            begin
                if (dig_beat && idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // byte writes, counters and engine commands
    always_comb
    begin
        fill_next   = fill_reg;
        len_next    = len_reg;
        wrap_next   = wrap_reg;
        ret_next    = ret_reg;
        idx_next    = idx_reg;
        ctl         = '0;
        ctl.wr_addr = fill_reg[5:0];
        msg_ready   = 1'b0;
        dig_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_beat)
                begin
                    ctl.wr_en   = has_byte;
                    ctl.wr_data = message_byte;
                    fill_next   = fill_after;
                    if (has_byte)
                    begin
                        len_next = len_reg + 64'd8;
                    end
                    ret_next = end_of_message ? ST_MARK : ST_IDLE;
                end
            end
            ST_MARK:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_data = PAD_MARK;
                fill_next   = fill_reg + 7'd1;
                wrap_next   = fill_reg >= LEN_START;
            end
            ST_ZERO:
            begin
                if (zero_done)
                begin
                    wrap_next = 1'b0;
                    ret_next  = ST_ZERO;
                end
                else
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_data = 8'd0;
                    fill_next   = fill_reg + 7'd1;
                end
            end
            ST_LEN:
            begin
                if (fill_reg == BLOCK_BYTES)
                begin
                    ret_next = ST_OUT;
                end
                else
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_data = len_reg[{~fill_reg[2:0], 3'b000} +: 8];
                    fill_next   = fill_reg + 7'd1;
                end
            end
            ST_START:
            begin
                ctl.start = stat.idle;
                fill_next = 7'd0;
            end
            ST_WAIT:
            begin
                ctl.start = 1'b0;
            end
            ST_OUT:
            begin
                dig_valid = 1'b1;
                if (dig_beat)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        ctl.restart = 1'b1;
                        fill_next   = 7'd0;
                        len_next    = 64'd0;
                    end
                end
            end
            default:
            begin
                ctl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= 7'd0;
            len_reg   <= 64'd0;
            wrap_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            wrap_reg  <= wrap_next;
            idx_reg   <= idx_next;
        end
    end

    // digest beat: two chain words, the even one on top
    assign digest_word = {chain[{idx_reg, 1'b0}], chain[{idx_reg, 1'b1}]};
    assign word_index  = idx_reg;
    assign last_word   = idx_reg == 2'd3;

endmodule

[hdl/shamh_checker.sv]
`include "assert_macros.svh"

module shamh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_ready,
    input logic        dig_valid,
    input logic        dig_ready,
    input logic [63:0] digest_word,
    input logic [1:0]  word_index,
    input logic        last_word
);

    // stalled digest beat holds
    `SHAMH_ASSERT(a_dig_hold, dig_valid && !dig_ready |=> dig_valid && $stable(digest_word) && $stable(word_index))

    // no new byte taken while the digest is going out
    `SHAMH_NEVER(a_busy_excl, msg_ready && dig_valid)

    // last flag marks the fourth word only
    `SHAMH_ASSERT(a_last_flag, dig_valid |-> last_word == (word_index == 2'd3))

    // digest words leave in order without gaps
    `SHAMH_ASSERT(a_word_order, dig_valid && dig_ready && !last_word |=> dig_valid && word_index == $past(word_index) + 2'd1)

    // after the final word the block takes the next message
    `SHAMH_ASSERT(a_reopen, dig_valid && dig_ready && last_word |=> msg_ready && !dig_valid)

endmodule

bind sha256_message_hasher_core shamh_checker u_shamh_checker (.*);
